// ===== hw/rtl/vgpd_pkg.sv =====
// Shared types and codes for the voxel grid point downsampler.
package vgpd_pkg;

  localparam logic [1:0] KIND_ADD     = 2'd0;
  localparam logic [1:0] KIND_DRAIN   = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  localparam logic [1:0] STAT_ENTRY   = 2'd0;
  localparam logic [1:0] STAT_EMPTY   = 2'd1;
  localparam logic [1:0] STAT_DROPPED = 2'd2;

  localparam int SUM_W  = 40;
  localparam int CNT_W  = 32;
  localparam int AVG_W  = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [SUM_W-1:0]   sum_r;
    logic [SUM_W-1:0]   sum_g;
    logic [SUM_W-1:0]   sum_b;
    logic [CNT_W-1:0]   cnt;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_DRAIN,
    OP_INSERT,
    OP_ACCUM
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   new_e;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SNAP,
    ST_CMP,
    ST_DIV
  } state_t;

endpackage

// ===== hw/rtl/voxel_grid_point_downsampler.sv =====
// Top level: snap stage, sorted chain of voxel cells, drain dividers, result register.
//
//  channel | ports               | direction | carries
//  in      | in_valid / in_ready | input     | point, drain or clear request
//  out     | out_valid/out_ready | output    | drained entry or status
//  cfg     | cfg_valid/cfg_ready | input     | grid_exponent write
//
// Add: capture, snap, then compare and shift the cell chain.
// Drain: runs the 16-step restoring dividers, then loads the result; clear resets the occupancy.
// One request at a time; in_ready is low while a result waits in the output register.
// Synchronous active-low reset empties the table at once; no clearing pass.
module voxel_grid_point_downsampler #(
  parameter int CAPACITY  = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_x_coord,
  input  logic signed [31:0] in_y_coord,
  input  logic signed [31:0] in_z_coord,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_voxel_x,
  output logic signed [31:0] out_voxel_y,
  output logic signed [31:0] out_voxel_z,
  output logic [15:0]        out_red_average,
  output logic [15:0]        out_green_average,
  output logic [15:0]        out_blue_average,
  output logic [31:0]        out_point_count,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [5:0]  cfg_data
);

  localparam int OCC_W = $clog2(CAPACITY + 1);

  function automatic logic signed [31:0] snap(input logic signed [31:0] v,
                                              input logic signed [5:0] e);
    logic signed [7:0] s;
    logic [32:0] a, lim, m, r;
    s = {{2{e[5]}}, e} + 8'(FRAC_BITS);
    if (s <= 8'sd0) return v;
    if (s >= 8'sd32) return '0;
    a   = v[31] ? (33'd0 - {v[31], v}) : {1'b0, v};
    lim = 33'd1 << s[4:0];
    m   = a & (lim - 33'd1);
    r   = a - m;
    if (m > (lim >> 1)) r = r + lim;
    if (v[31]) return 32'(33'd0 - r);
    if (r > 33'h07FFFFFFF) return 32'h7FFFFFFF;
    return r[31:0];
  endfunction

  vgpd_pkg::state_t state_r, state_nxt;
  logic signed [5:0] grid_r;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic signed [31:0] raw_x_r, raw_y_r, raw_z_r;
  logic [7:0]        red_r, green_r, blue_r;
  vgpd_pkg::entry_t  key_r;
  vgpd_pkg::entry_t  head_r;
  logic              last_r;
  vgpd_pkg::cell_ctl_t ctl;
  logic              in_acc, div_start, hit_any;
  logic [2:0]        div_done;
  logic [15:0]       q_r, q_g, q_b;
  logic              set_out, set_drop, set_empty;

  vgpd_pkg::entry_t cell_d [CAPACITY];
  logic [CAPACITY-1:0] move_v, hit_v;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic signed [31:0] out_x_r, out_y_r, out_z_r;
  logic [15:0] out_ra_r, out_ga_r, out_ba_r;
  logic [31:0] out_cnt_r;
  logic        out_last_r;

  assign in_ready  = (state_r == vgpd_pkg::ST_IDLE) && !out_valid_r;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign hit_any   = |hit_v;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      vgpd_cell #(.IDX(gi), .OCC_W(OCC_W)) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .occ      (occ_r),
        .prev_d   ((gi == 0) ? key_r : cell_d[(gi == 0) ? 0 : gi - 1]),
        .prev_move((gi == 0) ? 1'b0 : move_v[(gi == 0) ? 0 : gi - 1]),
        .next_d   (cell_d[(gi == CAPACITY - 1) ? gi : gi + 1]),
        .data_o   (cell_d[gi]),
        .move_o   (move_v[gi]),
        .hit_o    (hit_v[gi])
      );
    end
  endgenerate

  vgpd_div u_div_r (.clk(clk), .rst_n(rst_n), .start(div_start), .sum(cell_d[0].sum_r),
                    .count(cell_d[0].cnt), .quot(q_r), .done(div_done[0]));
  vgpd_div u_div_g (.clk(clk), .rst_n(rst_n), .start(div_start), .sum(cell_d[0].sum_g),
                    .count(cell_d[0].cnt), .quot(q_g), .done(div_done[1]));
  vgpd_div u_div_b (.clk(clk), .rst_n(rst_n), .start(div_start), .sum(cell_d[0].sum_b),
                    .count(cell_d[0].cnt), .quot(q_b), .done(div_done[2]));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vgpd_pkg::ST_IDLE: begin
        if (in_acc && in_kind == vgpd_pkg::KIND_ADD) state_nxt = vgpd_pkg::ST_SNAP;
        else if (in_acc && in_kind == vgpd_pkg::KIND_DRAIN && occ_r != '0)
          state_nxt = vgpd_pkg::ST_DIV;
      end
      vgpd_pkg::ST_SNAP: state_nxt = vgpd_pkg::ST_CMP;
      vgpd_pkg::ST_CMP:  state_nxt = vgpd_pkg::ST_IDLE;
      vgpd_pkg::ST_DIV:  if (div_done[0]) state_nxt = vgpd_pkg::ST_IDLE;
      default: state_nxt = vgpd_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctl.op    = vgpd_pkg::OP_HOLD;
    ctl.new_e = key_r;
    div_start = 1'b0;
    set_out   = 1'b0;
    set_drop  = 1'b0;
    set_empty = 1'b0;
    occ_nxt   = occ_r;
    case (state_r)
      vgpd_pkg::ST_IDLE: begin
        if (in_acc && in_kind == vgpd_pkg::KIND_CLEAR) occ_nxt = '0;
        if (in_acc && in_kind == vgpd_pkg::KIND_DRAIN) begin
          if (occ_r == '0) begin
            set_empty = 1'b1;
          end else begin
            div_start = 1'b1;
            ctl.op    = vgpd_pkg::OP_DRAIN;
            occ_nxt   = occ_r - 1'b1;
          end
        end
      end
      vgpd_pkg::ST_CMP: begin
        if (hit_any) begin
          ctl.op = vgpd_pkg::OP_ACCUM;
        end else if (occ_r == OCC_W'(CAPACITY)) begin
          set_drop = 1'b1;
        end else begin
          ctl.op  = vgpd_pkg::OP_INSERT;
          occ_nxt = occ_r + 1'b1;
        end
      end
      vgpd_pkg::ST_DIV: set_out = div_done[0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vgpd_pkg::ST_IDLE;
      occ_r       <= '0;
      grid_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      if (cfg_valid && cfg_ready) grid_r <= cfg_data;
      if (set_out || set_drop || set_empty) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      raw_x_r <= in_x_coord;
      raw_y_r <= in_y_coord;
      raw_z_r <= in_z_coord;
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
    end
    if (state_r == vgpd_pkg::ST_SNAP) begin
      key_r.x     <= snap(raw_x_r, grid_r);
      key_r.y     <= snap(raw_y_r, grid_r);
      key_r.z     <= snap(raw_z_r, grid_r);
      key_r.sum_r <= vgpd_pkg::SUM_W'(red_r);
      key_r.sum_g <= vgpd_pkg::SUM_W'(green_r);
      key_r.sum_b <= vgpd_pkg::SUM_W'(blue_r);
      key_r.cnt   <= vgpd_pkg::CNT_W'(1);
    end
    if (div_start) begin
      head_r <= cell_d[0];
      last_r <= (occ_r == OCC_W'(1));
    end
    if (set_out) begin
      out_status_r <= vgpd_pkg::STAT_ENTRY;
      out_x_r      <= head_r.x;
      out_y_r      <= head_r.y;
      out_z_r      <= head_r.z;
      out_ra_r     <= q_r;
      out_ga_r     <= q_g;
      out_ba_r     <= q_b;
      out_cnt_r    <= head_r.cnt;
      out_last_r   <= last_r;
    end else if (set_drop || set_empty) begin
      out_status_r <= set_drop ? vgpd_pkg::STAT_DROPPED : vgpd_pkg::STAT_EMPTY;
      out_x_r      <= '0;
      out_y_r      <= '0;
      out_z_r      <= '0;
      out_ra_r     <= '0;
      out_ga_r     <= '0;
      out_ba_r     <= '0;
      out_cnt_r    <= '0;
      out_last_r   <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_voxel_x       = out_x_r;
  assign out_voxel_y       = out_y_r;
  assign out_voxel_z       = out_z_r;
  assign out_red_average   = out_ra_r;
  assign out_green_average = out_ga_r;
  assign out_blue_average  = out_ba_r;
  assign out_point_count   = out_cnt_r;
  assign out_last          = out_last_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(CAPACITY)) else $error("occupancy beyond capacity");

  a_drain_dec: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> occ_r == $past(occ_r) - 1'b1) else $error("drain did not shrink table");

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    div_done[0] |-> div_done[1] && div_done[2]) else $error("dividers out of step");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == vgpd_pkg::ST_CMP |-> $onehot0(hit_v)) else $error("duplicate key in table");

endmodule

// ===== hw/rtl/vgpd_cell.sv =====
// One table cell: holds an entry, compares it with the new key, shifts with its neighbors.
module vgpd_cell #(
  parameter int IDX   = 0,
  parameter int OCC_W = 9
) (
  input  logic                clk,
  input  vgpd_pkg::cell_ctl_t ctl,
  input  logic [OCC_W-1:0]    occ,
  input  vgpd_pkg::entry_t    prev_d,
  input  logic                prev_move,
  input  vgpd_pkg::entry_t    next_d,
  output vgpd_pkg::entry_t    data_o,
  output logic                move_o,
  output logic                hit_o
);

  vgpd_pkg::entry_t data_r, data_nxt;
  logic valid, at_occ, gt, eq;

  assign valid  = OCC_W'(IDX) < occ;
  assign at_occ = OCC_W'(IDX) == occ;
  assign gt = (data_r.x > ctl.new_e.x) ||
              (data_r.x == ctl.new_e.x && ((data_r.y > ctl.new_e.y) ||
              (data_r.y == ctl.new_e.y && data_r.z > ctl.new_e.z)));
  assign eq = data_r.x == ctl.new_e.x && data_r.y == ctl.new_e.y &&
              data_r.z == ctl.new_e.z;
  assign hit_o  = valid && eq;
  assign move_o = (valid && gt) || at_occ;
  assign data_o = data_r;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      vgpd_pkg::OP_DRAIN: data_nxt = next_d;
      vgpd_pkg::OP_INSERT: begin
        if (move_o) data_nxt = prev_move ? prev_d : ctl.new_e;
      end
      vgpd_pkg::OP_ACCUM: begin
        if (hit_o && data_r.cnt != vgpd_pkg::CNT_MAX) begin
          data_nxt.sum_r = data_r.sum_r + ctl.new_e.sum_r;
          data_nxt.sum_g = data_r.sum_g + ctl.new_e.sum_g;
          data_nxt.sum_b = data_r.sum_b + ctl.new_e.sum_b;
          data_nxt.cnt   = data_r.cnt + 1'b1;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ===== hw/rtl/vgpd_div.sv =====
// Restoring divider, one quotient bit per cycle: floor(sum * 256 / count).
module vgpd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [vgpd_pkg::SUM_W-1:0]  sum,
  input  logic [vgpd_pkg::CNT_W-1:0]  count,
  output logic [vgpd_pkg::AVG_W-1:0]  quot,
  output logic                        done
);

  logic [31:0] rem_r, den_r;
  logic [15:0] low_r, q_r;
  logic [3:0]  step_r;
  logic        busy_r, done_r;
  logic [32:0] trial, diff;

  assign trial = {rem_r, low_r[15]};
  assign diff  = trial - {1'b0, den_r};
  assign quot  = q_r;
  assign done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == 4'hF) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= sum[39:8];
      low_r <= {sum[7:0], 8'h00};
      den_r <= count;
      q_r   <= '0;
    end else if (busy_r) begin
      low_r <= {low_r[14:0], 1'b0};
      if (!diff[32]) begin
        rem_r <= diff[31:0];
        q_r   <= {q_r[14:0], 1'b1};
      end else begin
        rem_r <= trial[31:0];
        q_r   <= {q_r[14:0], 1'b0};
      end
    end
  end

endmodule
